### src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Consequent must follow antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pbs_pkg.sv
// Types and constants for the prime bucket sizing block.
package pbs_pkg;

	localparam int WORD_W = 32;
	localparam int DIV_W = 17;
	localparam int SQ_W = 33;
	localparam int CNT_W = $clog2(WORD_W);
	localparam logic [WORD_W-1:0] SMALL_LIMIT = 32'd100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_CHECK,
		ST_DIV,
		ST_DECIDE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [DIV_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_rsp_t;

endpackage

### src/pbs_rem.sv
// Bit-serial remainder unit: one dividend bit per cycle.
module pbs_rem (
	input  logic              clk,
	input  logic              arst_n,
	input  pbs_pkg::div_req_t req,
	output pbs_pkg::div_rsp_t rsp
);
	import pbs_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [WORD_W-1:0] sh_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;
	logic              fits;
	logic [DIV_W-1:0]  rem_d;

	always_comb begin
		trial = {rem_q, sh_q[WORD_W-1]};
		diff = trial - {1'b0, req.divisor};
		fits = (trial >= {1'b0, req.divisor});
		rem_d = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			sh_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= rem_d;
			sh_q <= {sh_q[WORD_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem_zero = (rem_q == '0);

endmodule

### src/prime_bucket_size_top.sv
// Bucket sizing: next prime at or above the request, by trial division; a request
// up to SMALL_LIMIT passes unchanged (0 gives 1). Each candidate passes test and
// decide states; each odd trial divisor adds a bound check and a bit-serial remainder.
// An output state ends the item. One item at a time, in_ready only when idle.
// A finished result waits in the output register while the next item is taken.
// Reset clears the sequencer and the output valid; no other state survives an item.
`include "assert_macros.svh"

module prime_bucket_size_top #(
	parameter int WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [pbs_pkg::WORD_W-1:0] request_size,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [pbs_pkg::WORD_W-1:0] bucket_size,
	output logic                      request_is_prime,
	output logic                      no_prime_found
);
	import pbs_pkg::*;

	localparam logic [WORD_W-1:0] TOP = (WIDTH >= WORD_W) ? {WORD_W{1'b1}} :
		WORD_W'((64'd1 << WIDTH) - 64'd1);

	state_t state_q, state_d;

	logic [WORD_W-1:0] req_q;
	logic [WORD_W-1:0] cand_q;
	logic [DIV_W-1:0]  d_q;
	logic [SQ_W-1:0]   sq_q;
	logic              res_q;
	logic              first_q;
	logic              req_prime_q;
	logic [WORD_W-1:0] bucket_q;
	logic              none_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] bucket_out_q;
	logic              prime_out_q;
	logic              none_out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic in_accept;
	logic out_load;
	logic sq_over;
	logic test_done;
	logic test_res;
	logic dec_out;
	logic [WORD_W-1:0] dec_bucket;
	logic              dec_none;
	logic              cur_res;

	pbs_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Small-case screening of a candidate.
	always_comb begin
		test_done = 1'b1;
		test_res = 1'b0;
		priority if (cand_q < WORD_W'(2)) begin
			test_res = 1'b0;
		end else if (cand_q == WORD_W'(2)) begin
			test_res = 1'b1;
		end else if (!cand_q[0]) begin
			test_res = 1'b0;
		end else begin
			test_done = 1'b0;
		end
	end

	assign sq_over = (sq_q > {1'b0, cand_q});
	assign cur_res = res_q;

	// Decision after a candidate's verdict.
	always_comb begin
		dec_out = 1'b1;
		dec_bucket = req_q;
		dec_none = 1'b0;
		if (first_q) begin
			priority if (req_q <= SMALL_LIMIT) begin
				dec_bucket = (req_q == '0) ? WORD_W'(1) : req_q;
			end else if (cur_res && req_q <= TOP) begin
				dec_bucket = req_q;
			end else if (req_q >= TOP) begin
				dec_none = 1'b1;
			end else begin
				dec_out = 1'b0;
			end
		end else begin
			priority if (cur_res) begin
				dec_bucket = cand_q;
			end else if (cand_q == TOP) begin
				dec_none = 1'b1;
			end else begin
				dec_out = 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				state_d = test_done ? ST_DECIDE : ST_CHECK;
			end
			ST_CHECK: begin
				state_d = sq_over ? ST_DECIDE : ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = div_rsp.rem_zero ? ST_DECIDE : ST_CHECK;
				end
			end
			ST_DECIDE: begin
				state_d = dec_out ? ST_OUT : ST_TEST;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		div_req.start = (state_q == ST_CHECK) && !sq_over;
		div_req.dividend = cand_q;
		div_req.divisor = d_q;
		out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q <= request_size;
			cand_q <= request_size;
			first_q <= 1'b1;
		end
		if (state_q == ST_TEST) begin
			res_q <= test_res;
			d_q <= DIV_W'(3);
			sq_q <= SQ_W'(9);
		end
		if (state_q == ST_CHECK && sq_over) begin
			res_q <= 1'b1;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			res_q <= 1'b0;
			d_q <= d_q + DIV_W'(2);
			sq_q <= sq_q + {{(SQ_W - DIV_W - 2){1'b0}}, d_q, 2'b00} + SQ_W'(4);
		end
		if (state_q == ST_DECIDE) begin
			if (first_q) begin
				req_prime_q <= cur_res;
			end
			bucket_q <= dec_bucket;
			none_q <= dec_none;
			if (!dec_out) begin
				cand_q <= first_q ? req_q + WORD_W'(1) : cand_q + WORD_W'(1);
				first_q <= 1'b0;
			end
		end
		if (out_load) begin
			bucket_out_q <= bucket_q;
			prime_out_q <= req_prime_q;
			none_out_q <= none_q;
		end
	end

	assign out_valid = out_valid_q;
	assign bucket_size = bucket_out_q;
	assign request_is_prime = prime_out_q;
	assign no_prime_found = none_out_q;

	`ASSERT_IMPLIES(a_bucket_nonzero, clk, arst_n, out_valid, bucket_size != '0, "zero bucket size")
	`ASSERT_IMPLIES(a_done_in_div, clk, arst_n, div_rsp.done, state_q == ST_DIV, "remainder done outside divide")
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_accept, !in_ready, "ready right after accept")

endmodule
